// ----- sv/tjd_pkg.sv -----
// Shared types and constants of the threshold job dispatcher.
`timescale 1ns / 1ps
package tjd_pkg;

    localparam int WORKER_SLOTS = 4;
    localparam int SLOT_W       = 2;
    localparam int TAG_W        = 8;
    localparam int TAG_SLOTS    = 256;
    localparam int CLIENT_W     = 16;
    localparam int LOAD_W       = 8;
    localparam int WCOUNT_W     = 3;
    localparam int GROW_W       = 6;
    localparam int CFG_W        = 8;
    localparam int CFG_IDX_W    = 2;
    localparam int IN_DATA_W    = 32;
    localparam int IN_USER_W    = 4;
    localparam int OUT_DATA_W   = 32;
    localparam int OUT_USER_W   = 3;

    typedef enum logic [1:0] {
        CMD_REQUEST  = 2'd0,
        CMD_RESPONSE = 2'd1,
        CMD_ONLINE   = 2'd2,
        CMD_TICK     = 2'd3
    } cmd_t;

    localparam logic [1:0] CLS_PRIORITY = 2'd1;
    localparam logic [1:0] CLS_PROJECT  = 2'd2;

    typedef enum logic [2:0] {
        KIND_DISPATCH = 3'd0,
        KIND_RESPOND  = 3'd1,
        KIND_START    = 3'd2,
        KIND_KILL     = 3'd3,
        KIND_FILLED   = 3'd4,
        KIND_QUEUED   = 3'd5,
        KIND_NO_SLOT  = 3'd6,
        KIND_DROPPED  = 3'd7
    } kind_t;

    localparam logic [CFG_IDX_W-1:0] CFG_WORKER_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAIN_LIMIT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WORKER_LIMIT   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GROW_THRESHOLD = 2'd3;

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_CAPTURE,
        ACT_DISP_PRIO,
        ACT_DISP_NORMAL_NEW,
        ACT_DISP_PROJECT_NEW,
        ACT_DISP_NORMAL_Q,
        ACT_DISP_PROJECT_Q,
        ACT_NQ_PUSH,
        ACT_PQ_PUSH,
        ACT_START,
        ACT_RESPOND,
        ACT_ONLINE,
        ACT_KILL_STEP,
        ACT_FLUSH
    } action_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_NQ_PUSH,
        ST_GROW,
        ST_RSP,
        ST_NQ_CHK,
        ST_NQ_GO,
        ST_PQ_CHK,
        ST_PQ_GO,
        ST_REQ_PROJ,
        ST_START_PQ,
        ST_PQ_PUSH,
        ST_KILL,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        action_t action;
    } dp_cmd_t;

    typedef struct packed {
        cmd_t       command;
        logic [1:0] req_class;
        logic       can_emit;
        logic       pend_valid;
        logic       out_free;
        logic       prio_ok;
        logic       normal_found;
        logic       project_found;
        logic       nq_nonempty;
        logic       pq_nonempty;
        logic       start_ok;
        logic       grow_hit;
        logic       rsp_ok;
        logic       kill_more;
        logic       kill_hit;
    } dp_status_t;

endpackage

// ----- sv/tjd_ctrl.sv -----
// Sequencing state machine of the threshold job dispatcher.
`timescale 1ns / 1ps
module tjd_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  tjd_pkg::dp_status_t status,
    output tjd_pkg::dp_cmd_t    cmd
);
    import tjd_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_DECODE;
            end
            ST_DECODE: begin
                unique case (status.command)
                    CMD_REQUEST: begin
                        if (status.req_class == CLS_PROJECT) begin
                            state_next = ST_PQ_CHK;
                        end else if ((status.req_class == CLS_PRIORITY && status.prio_ok)
                                     || status.normal_found) begin
                            if (status.can_emit) state_next = ST_FLUSH;
                        end else begin
                            state_next = ST_NQ_PUSH;
                        end
                    end
                    CMD_RESPONSE: state_next = ST_RSP;
                    CMD_ONLINE: begin
                        if (status.can_emit) state_next = ST_FLUSH;
                    end
                    CMD_TICK: state_next = ST_NQ_CHK;
                    default: state_next = ST_FLUSH;
                endcase
            end
            ST_NQ_PUSH: begin
                if (status.can_emit) state_next = ST_GROW;
            end
            ST_GROW: begin
                if (!(status.grow_hit && status.start_ok) || status.can_emit) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_RSP: begin
                if (!status.rsp_ok || status.can_emit) state_next = ST_FLUSH;
            end
            ST_NQ_CHK: begin
                if (status.nq_nonempty && status.normal_found) state_next = ST_NQ_GO;
                else state_next = ST_PQ_CHK;
            end
            ST_NQ_GO: begin
                if (status.can_emit) state_next = ST_NQ_CHK;
            end
            ST_PQ_CHK: begin
                if (status.pq_nonempty && status.project_found) begin
                    state_next = ST_PQ_GO;
                end else if (status.command == CMD_REQUEST) begin
                    state_next = ST_REQ_PROJ;
                end else begin
                    state_next = ST_KILL;
                end
            end
            ST_PQ_GO: begin
                if (status.can_emit) state_next = ST_PQ_CHK;
            end
            ST_REQ_PROJ: begin
                if (!status.project_found) state_next = ST_START_PQ;
                else if (status.can_emit) state_next = ST_FLUSH;
            end
            ST_START_PQ: begin
                if (!status.start_ok || status.can_emit) state_next = ST_PQ_PUSH;
            end
            ST_PQ_PUSH: begin
                if (status.can_emit) state_next = ST_FLUSH;
            end
            ST_KILL: begin
                if (!status.kill_more) state_next = ST_FLUSH;
            end
            ST_FLUSH: begin
                if (!status.pend_valid || status.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd.action = ACT_NONE;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) cmd.action = ACT_CAPTURE;
            end
            ST_DECODE: begin
                if (status.command == CMD_REQUEST && status.req_class != CLS_PROJECT
                    && status.can_emit) begin
                    if (status.req_class == CLS_PRIORITY && status.prio_ok) begin
                        cmd.action = ACT_DISP_PRIO;
                    end else if (status.normal_found) begin
                        cmd.action = ACT_DISP_NORMAL_NEW;
                    end
                end else if (status.command == CMD_ONLINE && status.can_emit) begin
                    cmd.action = ACT_ONLINE;
                end
            end
            ST_NQ_PUSH: begin
                if (status.can_emit) cmd.action = ACT_NQ_PUSH;
            end
            ST_GROW: begin
                if (status.grow_hit && status.start_ok && status.can_emit) begin
                    cmd.action = ACT_START;
                end
            end
            ST_RSP: begin
                if (status.rsp_ok && status.can_emit) cmd.action = ACT_RESPOND;
            end
            ST_NQ_GO: begin
                if (status.can_emit) cmd.action = ACT_DISP_NORMAL_Q;
            end
            ST_PQ_GO: begin
                if (status.can_emit) cmd.action = ACT_DISP_PROJECT_Q;
            end
            ST_REQ_PROJ: begin
                if (status.project_found && status.can_emit) cmd.action = ACT_DISP_PROJECT_NEW;
            end
            ST_START_PQ: begin
                if (status.start_ok && status.can_emit) cmd.action = ACT_START;
            end
            ST_PQ_PUSH: begin
                if (status.can_emit) cmd.action = ACT_PQ_PUSH;
            end
            ST_KILL: begin
                if (status.kill_more && (!status.kill_hit || status.can_emit)) begin
                    cmd.action = ACT_KILL_STEP;
                end
            end
            ST_FLUSH: begin
                if (status.pend_valid && status.out_free) cmd.action = ACT_FLUSH;
            end
            default: cmd.action = ACT_NONE;
        endcase
    end

endmodule

// ----- sv/tjd_datapath.sv -----
// Slot table, tag table, job queues and result staging of the dispatcher.
`timescale 1ns / 1ps
module tjd_datapath #(
    parameter int NORMAL_QUEUE_DEPTH  = 32,
    parameter int PROJECT_QUEUE_DEPTH = 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic [tjd_pkg::IN_DATA_W-1:0]      s_tdata,
    input  logic [tjd_pkg::IN_USER_W-1:0]      s_tuser,
    input  logic                               cfg_wr_en,
    input  logic [tjd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tjd_pkg::CFG_W-1:0]          cfg_data,
    input  tjd_pkg::dp_cmd_t                   cmd,
    output tjd_pkg::dp_status_t                status,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [tjd_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic [tjd_pkg::OUT_USER_W-1:0]     m_tuser,
    output logic                               m_tlast
);
    import tjd_pkg::*;

    localparam int NQ_AW  = $clog2(NORMAL_QUEUE_DEPTH);
    localparam int NQ_CW  = $clog2(NORMAL_QUEUE_DEPTH + 1);
    localparam int NQ_SW  = NQ_AW + 1;
    localparam int PQ_AW  = $clog2(PROJECT_QUEUE_DEPTH);
    localparam int PQ_CW  = $clog2(PROJECT_QUEUE_DEPTH + 1);
    localparam int PQ_SW  = PQ_AW + 1;
    localparam int CMP_W  = (NQ_CW > GROW_W) ? NQ_CW : GROW_W;
    localparam int ENTRY_W = TAG_W + CLIENT_W;
    localparam int OWNER_W = SLOT_W + CLIENT_W;
    localparam int KIDX_W  = SLOT_W + 1;

    // Configuration registers.
    logic [WCOUNT_W-1:0] worker_count_reg;
    logic [LOAD_W-1:0]   main_limit_reg;
    logic [LOAD_W-1:0]   worker_limit_reg;
    logic [GROW_W-1:0]   grow_threshold_reg;

    // Captured transaction.
    cmd_t                in_cmd_reg;
    logic [1:0]          in_class_reg;
    logic [CLIENT_W-1:0] in_client_reg;
    logic [SLOT_W-1:0]   in_worker_reg;
    logic [TAG_W-1:0]    in_tag_reg;
    logic [TAG_W-1:0]    req_tag_reg;
    logic [TAG_W-1:0]    next_tag_reg;

    // Slot table.
    logic [WORKER_SLOTS-1:0]             live_reg, live_next;
    logic [WORKER_SLOTS-1:0][LOAD_W-1:0] load_reg, load_next;
    logic [WORKER_SLOTS-1:0]             has_proj_reg, has_proj_next;
    logic [WORKER_SLOTS-1:0][TAG_W-1:0]  proj_tag_reg, proj_tag_next;
    logic [WCOUNT_W-1:0]                 live_count_reg, live_count_next;
    logic                                booting_reg, booting_next;
    logic [KIDX_W-1:0]                   kill_idx_reg, kill_idx_next;

    // Tag table: valid bits in flops, owner data in a memory.
    logic [TAG_SLOTS-1:0] tag_valid_reg, tag_valid_next;
    logic [OWNER_W-1:0]   tag_mem [TAG_SLOTS];
    logic [OWNER_W-1:0]   tag_rd_reg;

    // Queues.
    logic [ENTRY_W-1:0] nq_mem [NORMAL_QUEUE_DEPTH];
    logic [ENTRY_W-1:0] nq_rd_reg;
    logic [NQ_AW-1:0]   nq_head_reg, nq_head_next;
    logic [NQ_CW-1:0]   nq_count_reg, nq_count_next;
    logic [ENTRY_W-1:0] pq_mem [PROJECT_QUEUE_DEPTH];
    logic [ENTRY_W-1:0] pq_rd_reg;
    logic [PQ_AW-1:0]   pq_head_reg, pq_head_next;
    logic [PQ_CW-1:0]   pq_count_reg, pq_count_next;

    // Result staging: one pending result plus the output register.
    logic                pend_valid_reg, pend_valid_next;
    kind_t               pend_kind_reg;
    logic [SLOT_W-1:0]   pend_slot_reg;
    logic [TAG_W-1:0]    pend_tag_reg;
    logic [CLIENT_W-1:0] pend_client_reg;
    logic                out_valid_reg, out_valid_next;
    kind_t               out_kind_reg;
    logic [SLOT_W-1:0]   out_slot_reg;
    logic [TAG_W-1:0]    out_tag_reg;
    logic [CLIENT_W-1:0] out_client_reg;
    logic                out_last_reg;

    logic [WORKER_SLOTS-1:0] used;
    logic [WCOUNT_W-1:0]     slots_n;
    logic                    normal_found, project_found, free_found;
    logic [SLOT_W-1:0]       normal_slot, project_slot, free_slot;
    logic [NQ_AW-1:0]        nq_tail;
    logic [NQ_SW-1:0]        nq_sum;
    logic [PQ_AW-1:0]        pq_tail;
    logic [PQ_SW-1:0]        pq_sum;
    logic                    nq_full, pq_full;
    logic                    nq_push, nq_pop, pq_push, pq_pop;
    logic                    out_free, can_emit, out_load, out_last_in;
    logic                    emit_en;
    kind_t                   emit_kind;
    logic [SLOT_W-1:0]       emit_slot;
    logic [TAG_W-1:0]        emit_tag;
    logic [CLIENT_W-1:0]     emit_client;
    logic                    disp_en, disp_project;
    logic [SLOT_W-1:0]       disp_slot;
    logic [TAG_W-1:0]        disp_tag;
    logic [CLIENT_W-1:0]     disp_client;
    logic                    rsp_ok, kill_more, kill_hit, start_ok, grow_hit;
    logic [SLOT_W-1:0]       kill_slot;
    logic                    capture;

    assign capture = (cmd.action == ACT_CAPTURE);

    always_comb begin
        for (int i = 0; i < WORKER_SLOTS; i++) begin
            used[i] = (worker_count_reg > WCOUNT_W'(i));
        end
        slots_n = (worker_count_reg > WCOUNT_W'(WORKER_SLOTS)) ? WCOUNT_W'(WORKER_SLOTS)
                                                                : worker_count_reg;
    end

    // Slot choices; scanning from the top down leaves the lowest match.
    always_comb begin
        normal_found  = 1'b0;
        normal_slot   = '0;
        project_found = 1'b0;
        project_slot  = '0;
        free_found    = 1'b0;
        free_slot     = '0;
        if (used[0] && live_reg[0] && load_reg[0] < main_limit_reg) begin
            normal_found = 1'b1;
        end else begin
            for (int i = WORKER_SLOTS - 1; i >= 1; i--) begin
                if (used[i] && live_reg[i] && load_reg[i] < worker_limit_reg) begin
                    normal_found = 1'b1;
                    normal_slot  = SLOT_W'(i);
                end
            end
        end
        for (int i = WORKER_SLOTS - 1; i >= 0; i--) begin
            if (used[i] && live_reg[i] && !has_proj_reg[i]) begin
                project_found = 1'b1;
                project_slot  = SLOT_W'(i);
            end
            if (used[i] && !live_reg[i]) begin
                free_found = 1'b1;
                free_slot  = SLOT_W'(i);
            end
        end
    end

    always_comb begin
        nq_sum  = NQ_SW'(nq_head_reg) + NQ_SW'(nq_count_reg);
        nq_tail = (nq_sum >= NQ_SW'(NORMAL_QUEUE_DEPTH))
                  ? NQ_AW'(nq_sum - NQ_SW'(NORMAL_QUEUE_DEPTH)) : NQ_AW'(nq_sum);
        pq_sum  = PQ_SW'(pq_head_reg) + PQ_SW'(pq_count_reg);
        pq_tail = (pq_sum >= PQ_SW'(PROJECT_QUEUE_DEPTH))
                  ? PQ_AW'(pq_sum - PQ_SW'(PROJECT_QUEUE_DEPTH)) : PQ_AW'(pq_sum);
        nq_full = (nq_count_reg == NQ_CW'(NORMAL_QUEUE_DEPTH));
        pq_full = (pq_count_reg == PQ_CW'(PROJECT_QUEUE_DEPTH));
    end

    assign start_ok  = (live_count_reg < slots_n) && !booting_reg;
    assign grow_hit  = (CMP_W'(nq_count_reg) >= CMP_W'(grow_threshold_reg));
    assign rsp_ok    = tag_valid_reg[in_tag_reg] && live_reg[in_worker_reg]
                       && (tag_rd_reg[OWNER_W-1 -: SLOT_W] == in_worker_reg);
    assign kill_slot = kill_idx_reg[SLOT_W-1:0];
    assign kill_more = (WCOUNT_W'(kill_idx_reg) < slots_n) && (live_count_reg > WCOUNT_W'(1));
    assign kill_hit  = live_reg[kill_slot] && (load_reg[kill_slot] == '0);
    assign out_free  = !out_valid_reg || m_tready;
    assign can_emit  = !pend_valid_reg || out_free;

    // Decode the action into a dispatch, a queue operation and a result.
    always_comb begin
        disp_en      = 1'b0;
        disp_project = 1'b0;
        disp_slot    = '0;
        disp_tag     = req_tag_reg;
        disp_client  = in_client_reg;
        nq_push      = 1'b0;
        nq_pop       = 1'b0;
        pq_push      = 1'b0;
        pq_pop       = 1'b0;
        emit_en      = 1'b0;
        emit_kind    = KIND_DISPATCH;
        emit_slot    = '0;
        emit_tag     = '0;
        emit_client  = '0;
        unique case (cmd.action)
            ACT_DISP_PRIO: begin
                disp_en = 1'b1;
            end
            ACT_DISP_NORMAL_NEW: begin
                disp_en   = 1'b1;
                disp_slot = normal_slot;
            end
            ACT_DISP_PROJECT_NEW: begin
                disp_en      = 1'b1;
                disp_slot    = project_slot;
                disp_project = 1'b1;
            end
            ACT_DISP_NORMAL_Q: begin
                disp_en     = 1'b1;
                disp_slot   = normal_slot;
                disp_tag    = nq_rd_reg[ENTRY_W-1 -: TAG_W];
                disp_client = nq_rd_reg[CLIENT_W-1:0];
                nq_pop      = 1'b1;
            end
            ACT_DISP_PROJECT_Q: begin
                disp_en      = 1'b1;
                disp_slot    = project_slot;
                disp_tag     = pq_rd_reg[ENTRY_W-1 -: TAG_W];
                disp_client  = pq_rd_reg[CLIENT_W-1:0];
                disp_project = 1'b1;
                pq_pop       = 1'b1;
            end
            ACT_NQ_PUSH: begin
                nq_push     = !nq_full;
                emit_en     = 1'b1;
                emit_kind   = nq_full ? KIND_DROPPED : KIND_QUEUED;
                emit_tag    = req_tag_reg;
                emit_client = in_client_reg;
            end
            ACT_PQ_PUSH: begin
                pq_push     = !pq_full;
                emit_en     = 1'b1;
                emit_kind   = pq_full ? KIND_DROPPED : KIND_QUEUED;
                emit_tag    = req_tag_reg;
                emit_client = in_client_reg;
            end
            ACT_START: begin
                emit_en   = 1'b1;
                emit_kind = KIND_START;
            end
            ACT_RESPOND: begin
                emit_en     = 1'b1;
                emit_kind   = KIND_RESPOND;
                emit_slot   = in_worker_reg;
                emit_tag    = in_tag_reg;
                emit_client = tag_rd_reg[CLIENT_W-1:0];
            end
            ACT_ONLINE: begin
                emit_en   = 1'b1;
                emit_kind = free_found ? KIND_FILLED : KIND_NO_SLOT;
                emit_slot = free_found ? free_slot : '0;
            end
            ACT_KILL_STEP: begin
                emit_en   = kill_hit;
                emit_kind = KIND_KILL;
                emit_slot = kill_slot;
            end
            default: begin
            end
        endcase
        if (disp_en) begin
            emit_en     = 1'b1;
            emit_kind   = KIND_DISPATCH;
            emit_slot   = disp_slot;
            emit_tag    = disp_tag;
            emit_client = disp_client;
        end
    end

    // Slot table and bookkeeping updates.
    always_comb begin
        live_next       = live_reg;
        load_next       = load_reg;
        has_proj_next   = has_proj_reg;
        proj_tag_next   = proj_tag_reg;
        live_count_next = live_count_reg;
        booting_next    = booting_reg;
        kill_idx_next   = kill_idx_reg;
        tag_valid_next  = tag_valid_reg;
        if (capture) begin
            kill_idx_next = KIDX_W'(1);
        end
        if (disp_en) begin
            if (load_reg[disp_slot] != '1) load_next[disp_slot] = load_reg[disp_slot] + 1'b1;
            tag_valid_next[disp_tag] = 1'b1;
            if (disp_project) begin
                has_proj_next[disp_slot] = 1'b1;
                proj_tag_next[disp_slot] = disp_tag;
            end
        end
        unique case (cmd.action)
            ACT_START: begin
                booting_next = 1'b1;
            end
            ACT_RESPOND: begin
                tag_valid_next[in_tag_reg] = 1'b0;
                if (load_reg[in_worker_reg] != '0) begin
                    load_next[in_worker_reg] = load_reg[in_worker_reg] - 1'b1;
                end
                if (has_proj_reg[in_worker_reg] && proj_tag_reg[in_worker_reg] == in_tag_reg) begin
                    has_proj_next[in_worker_reg] = 1'b0;
                    proj_tag_next[in_worker_reg] = '0;
                end
            end
            ACT_ONLINE: begin
                booting_next = 1'b0;
                if (free_found) begin
                    live_next[free_slot]     = 1'b1;
                    load_next[free_slot]     = '0;
                    has_proj_next[free_slot] = 1'b0;
                    proj_tag_next[free_slot] = '0;
                    live_count_next          = live_count_reg + 1'b1;
                end
            end
            ACT_KILL_STEP: begin
                kill_idx_next = kill_idx_reg + 1'b1;
                if (kill_hit) begin
                    live_next[kill_slot]     = 1'b0;
                    has_proj_next[kill_slot] = 1'b0;
                    proj_tag_next[kill_slot] = '0;
                    live_count_next          = live_count_reg - 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        nq_head_next  = nq_head_reg;
        nq_count_next = nq_count_reg;
        pq_head_next  = pq_head_reg;
        pq_count_next = pq_count_reg;
        if (nq_push) nq_count_next = nq_count_reg + 1'b1;
        if (nq_pop) begin
            nq_count_next = nq_count_reg - 1'b1;
            nq_head_next  = (nq_head_reg == NQ_AW'(NORMAL_QUEUE_DEPTH - 1)) ? '0
                                                                            : nq_head_reg + 1'b1;
        end
        if (pq_push) pq_count_next = pq_count_reg + 1'b1;
        if (pq_pop) begin
            pq_count_next = pq_count_reg - 1'b1;
            pq_head_next  = (pq_head_reg == PQ_AW'(PROJECT_QUEUE_DEPTH - 1)) ? '0
                                                                             : pq_head_reg + 1'b1;
        end
    end

    // A new result pushes the pending one out; the flush marks it as the last.
    always_comb begin
        out_load        = 1'b0;
        out_last_in     = 1'b0;
        pend_valid_next = pend_valid_reg;
        if (emit_en) begin
            out_load        = pend_valid_reg;
            pend_valid_next = 1'b1;
        end else if (cmd.action == ACT_FLUSH) begin
            out_load        = pend_valid_reg;
            out_last_in     = 1'b1;
            pend_valid_next = 1'b0;
        end
        if (out_load) out_valid_next = 1'b1;
        else if (m_tready) out_valid_next = 1'b0;
        else out_valid_next = out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            worker_count_reg   <= WCOUNT_W'(4);
            main_limit_reg     <= LOAD_W'(23);
            worker_limit_reg   <= LOAD_W'(24);
            grow_threshold_reg <= GROW_W'(12);
            next_tag_reg       <= '0;
            live_reg           <= '0;
            load_reg           <= '0;
            has_proj_reg       <= '0;
            proj_tag_reg       <= '0;
            live_count_reg     <= '0;
            booting_reg        <= 1'b0;
            kill_idx_reg       <= '0;
            tag_valid_reg      <= '0;
            nq_head_reg        <= '0;
            nq_count_reg       <= '0;
            pq_head_reg        <= '0;
            pq_count_reg       <= '0;
            pend_valid_reg     <= 1'b0;
            out_valid_reg      <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_WORKER_COUNT:   worker_count_reg   <= cfg_data[WCOUNT_W-1:0];
                    CFG_MAIN_LIMIT:     main_limit_reg     <= cfg_data[LOAD_W-1:0];
                    CFG_WORKER_LIMIT:   worker_limit_reg   <= cfg_data[LOAD_W-1:0];
                    CFG_GROW_THRESHOLD: grow_threshold_reg <= cfg_data[GROW_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (capture && cmd_t'(s_tuser[1:0]) == CMD_REQUEST) begin
                next_tag_reg <= next_tag_reg + 1'b1;
            end
            live_reg       <= live_next;
            load_reg       <= load_next;
            has_proj_reg   <= has_proj_next;
            proj_tag_reg   <= proj_tag_next;
            live_count_reg <= live_count_next;
            booting_reg    <= booting_next;
            kill_idx_reg   <= kill_idx_next;
            tag_valid_reg  <= tag_valid_next;
            nq_head_reg    <= nq_head_next;
            nq_count_reg   <= nq_count_next;
            pq_head_reg    <= pq_head_next;
            pq_count_reg   <= pq_count_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (capture) begin
            in_cmd_reg    <= cmd_t'(s_tuser[1:0]);
            in_class_reg  <= s_tuser[3:2];
            in_client_reg <= s_tdata[15:0];
            in_worker_reg <= s_tdata[17:16];
            in_tag_reg    <= s_tdata[25:18];
            req_tag_reg   <= next_tag_reg;
        end
        if (emit_en) begin
            pend_kind_reg   <= emit_kind;
            pend_slot_reg   <= emit_slot;
            pend_tag_reg    <= emit_tag;
            pend_client_reg <= emit_client;
        end
        if (out_load) begin
            out_kind_reg   <= pend_kind_reg;
            out_slot_reg   <= pend_slot_reg;
            out_tag_reg    <= pend_tag_reg;
            out_client_reg <= pend_client_reg;
            out_last_reg   <= out_last_in;
        end
    end

    // Memories with registered reads.
    always_ff @(posedge aclk) begin
        if (disp_en) tag_mem[disp_tag] <= {disp_slot, disp_client};
        tag_rd_reg <= tag_mem[in_tag_reg];
        if (nq_push) nq_mem[nq_tail] <= {req_tag_reg, in_client_reg};
        nq_rd_reg <= nq_mem[nq_head_reg];
        if (pq_push) pq_mem[pq_tail] <= {req_tag_reg, in_client_reg};
        pq_rd_reg <= pq_mem[pq_head_reg];
    end

    always_comb begin
        status.command       = in_cmd_reg;
        status.req_class     = in_class_reg;
        status.can_emit      = can_emit;
        status.pend_valid    = pend_valid_reg;
        status.out_free      = out_free;
        status.prio_ok       = used[0] && live_reg[0];
        status.normal_found  = normal_found;
        status.project_found = project_found;
        status.nq_nonempty   = (nq_count_reg != '0);
        status.pq_nonempty   = (pq_count_reg != '0);
        status.start_ok      = start_ok;
        status.grow_hit      = grow_hit;
        status.rsp_ok        = rsp_ok;
        status.kill_more     = kill_more;
        status.kill_hit      = kill_hit;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_client_reg, out_tag_reg, out_slot_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ----- sv/threshold_job_dispatcher.sv -----
// Top level of the threshold job dispatcher.
// The block takes one transaction at a time and answers it with zero or more results, the
// last one flagged by m_tlast. A dispatched normal or priority request and an online event
// pass through accept, decode and flush. A response adds a step for the tag-table read. A
// queued or dropped normal request runs the queue step and the start check before the flush.
// A project request first dispatches waiting project jobs, then is dispatched to a slot or,
// if none is found, asks for a start and queues. A tick dispatches queued jobs, then waiting
// project jobs, then scans the worker slots for idle kills. A result held on m_tdata for a
// stalled consumer stalls the sequencer whenever the staged result has to move into the
// output register. That happens on every result after the first of a transaction and at
// its final flush. The tag valid bits are flops cleared by reset, so the block is ready
// right after reset.
`timescale 1ns / 1ps
module threshold_job_dispatcher #(
    parameter int NORMAL_QUEUE_DEPTH  = 32,
    parameter int PROJECT_QUEUE_DEPTH = 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // client[15:0], worker[17:16], tag[25:18]
    input  logic [tjd_pkg::IN_DATA_W-1:0]  s_tdata,
    // command[1:0], request_class[3:2]
    input  logic [tjd_pkg::IN_USER_W-1:0]  s_tuser,
    input  logic                           cfg_wr_en,
    input  logic [tjd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tjd_pkg::CFG_W-1:0]      cfg_data,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // slot[1:0], job_tag[9:2], client_id[25:10]
    output logic [tjd_pkg::OUT_DATA_W-1:0] m_tdata,
    // kind[2:0]
    output logic [tjd_pkg::OUT_USER_W-1:0] m_tuser,
    output logic                           m_tlast
);
    import tjd_pkg::*;

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    tjd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (dp_status),
        .cmd      (dp_cmd)
    );

    tjd_datapath #(
        .NORMAL_QUEUE_DEPTH  (NORMAL_QUEUE_DEPTH),
        .PROJECT_QUEUE_DEPTH (PROJECT_QUEUE_DEPTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (dp_cmd),
        .status    (dp_status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

// ----- sv/tjd_checker.sv -----
// Port-level checks of the threshold job dispatcher and their binding.
`timescale 1ns / 1ps
module tjd_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [tjd_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic [tjd_pkg::OUT_USER_W-1:0] m_tuser,
    input logic                           m_tlast
);
    import tjd_pkg::*;

    // A transaction is decoded before the next one can be taken.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted on two consecutive cycles");

    // A worker start request carries no slot, tag or client.
    a_start_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_START |-> m_tdata == '0)
        else $error("start worker result with nonzero payload");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_valid_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn while stalled");

    a_payload_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
        else $error("result payload changed while stalled");

endmodule

bind threshold_job_dispatcher tjd_checker u_tjd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ----- dv/tb_top.sv -----
// Self-checking testbench of the threshold job dispatcher: directed table, then random traffic.
`timescale 1ns / 1ps
module tb_top;
    import tjd_pkg::*;

    localparam int NQ_DEPTH = 32;
    localparam int PQ_DEPTH = 8;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        kind_t       kind;
        logic [1:0]  slot;
        logic [7:0]  job_tag;
        logic [15:0] client_id;
        logic        last;
    } outcome_t;

    typedef struct packed {
        cmd_t        command;
        logic [1:0]  req_class;
        logic [15:0] client;
        logic [1:0]  worker;
        logic [7:0]  tag;
    } event_t;

    // A directed row; when has_fixed is set the first outcome is compared with fixed_kind.
    typedef struct packed {
        event_t ev;
        logic   has_fixed;
        kind_t  fixed_kind;
    } row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_DATA_W-1:0] s_tdata = '0;
    logic [IN_USER_W-1:0] s_tuser = '0;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;
    logic m_tlast;

    threshold_job_dispatcher i_dut (.*);

    always #5 aclk = ~aclk;

    // Predictor state of the dispatcher.
    logic [2:0]  cur_workers;
    logic [7:0]  cur_main_limit, cur_worker_limit;
    logic [5:0]  cur_grow;
    logic        live [WORKER_SLOTS];
    logic [7:0]  load [WORKER_SLOTS];
    logic        has_proj [WORKER_SLOTS];
    logic [7:0]  proj_tag [WORKER_SLOTS];
    logic        own_valid [TAG_SLOTS];
    logic [1:0]  own_slot [TAG_SLOTS];
    logic [15:0] own_client [TAG_SLOTS];
    logic [23:0] nq [NQ_DEPTH];
    int          nq_head, nq_cnt;
    logic [23:0] pq [PQ_DEPTH];
    int          pq_head, pq_cnt;
    logic [7:0]  tag_next;
    int          live_cnt;
    logic        boot_pending;

    outcome_t expected_q[$];
    int       errors = 0;
    int       idle_cycles = 0;

    function automatic int slots_in_use();
        return cur_workers < WORKER_SLOTS ? int'(cur_workers) : WORKER_SLOTS;
    endfunction

    function automatic void push_outcome(kind_t k, int s, logic [7:0] t, logic [15:0] c);
        outcome_t o;
        o.kind = k;
        o.slot = s[1:0];
        o.job_tag = t;
        o.client_id = c;
        o.last = 1'b0;
        expected_q.push_back(o);
    endfunction

    function automatic int normal_target();
        int n;
        n = slots_in_use();
        if (n > 0 && live[0] && load[0] < cur_main_limit) return 0;
        for (int i = 1; i < n; i++)
            if (live[i] && load[i] < cur_worker_limit) return i;
        return -1;
    endfunction

    function automatic int project_target();
        int n;
        n = slots_in_use();
        for (int i = 0; i < n; i++)
            if (live[i] && !has_proj[i]) return i;
        return -1;
    endfunction

    function automatic void give_job(int s, logic [7:0] t, logic [15:0] c, bit proj);
        if (load[s] != 8'hFF) load[s]++;
        own_valid[t] = 1'b1;
        own_slot[t] = s[1:0];
        own_client[t] = c;
        if (proj) begin
            has_proj[s] = 1'b1;
            proj_tag[s] = t;
        end
        push_outcome(KIND_DISPATCH, s, t, c);
    endfunction

    function automatic void ask_start();
        if (live_cnt < slots_in_use() && !boot_pending) begin
            boot_pending = 1'b1;
            push_outcome(KIND_START, 0, 8'd0, 16'd0);
        end
    endfunction

    function automatic void drain_projects();
        int s;
        while (pq_cnt > 0) begin
            s = project_target();
            if (s < 0) break;
            give_job(s, pq[pq_head][7:0], pq[pq_head][23:8], 1'b1);
            pq_head = (pq_head + 1) % PQ_DEPTH;
            pq_cnt--;
        end
    endfunction

    function automatic void reset_predictor();
        cur_workers = 3'd4;
        cur_main_limit = 8'd23;
        cur_worker_limit = 8'd24;
        cur_grow = 6'd12;
        for (int i = 0; i < WORKER_SLOTS; i++) begin
            live[i] = 0; load[i] = 0; has_proj[i] = 0; proj_tag[i] = 0;
        end
        for (int i = 0; i < TAG_SLOTS; i++) begin
            own_valid[i] = 0; own_slot[i] = 0; own_client[i] = 0;
        end
        nq_head = 0; nq_cnt = 0; pq_head = 0; pq_cnt = 0;
        tag_next = 0; live_cnt = 0; boot_pending = 0;
    endfunction

    // Returns the number of outcomes appended for this event.
    function automatic int predict_event(event_t ev);
        int before_n, s, n;
        logic [7:0] t;
        before_n = expected_q.size();
        n = slots_in_use();
        case (ev.command)
            CMD_REQUEST: begin
                t = tag_next;
                tag_next++;
                if (ev.req_class == CLS_PROJECT) begin
                    drain_projects();
                    s = project_target();
                    if (s >= 0) give_job(s, t, ev.client, 1'b1);
                    else begin
                        ask_start();
                        if (pq_cnt < PQ_DEPTH) begin
                            pq[(pq_head + pq_cnt) % PQ_DEPTH] = {ev.client, t};
                            pq_cnt++;
                            push_outcome(KIND_QUEUED, 0, t, ev.client);
                        end else push_outcome(KIND_DROPPED, 0, t, ev.client);
                    end
                end else if (ev.req_class == CLS_PRIORITY && n > 0 && live[0]) begin
                    give_job(0, t, ev.client, 1'b0);
                end else begin
                    s = normal_target();
                    if (s >= 0) give_job(s, t, ev.client, 1'b0);
                    else begin
                        if (nq_cnt < NQ_DEPTH) begin
                            nq[(nq_head + nq_cnt) % NQ_DEPTH] = {ev.client, t};
                            nq_cnt++;
                            push_outcome(KIND_QUEUED, 0, t, ev.client);
                        end else push_outcome(KIND_DROPPED, 0, t, ev.client);
                        if (nq_cnt >= cur_grow) ask_start();
                    end
                end
            end
            CMD_RESPONSE: begin
                t = ev.tag;
                if (live[ev.worker] && own_valid[t] && own_slot[t] == ev.worker) begin
                    own_valid[t] = 1'b0;
                    if (load[ev.worker] != 0) load[ev.worker]--;
                    if (has_proj[ev.worker] && proj_tag[ev.worker] == t) begin
                        has_proj[ev.worker] = 1'b0;
                        proj_tag[ev.worker] = 0;
                    end
                    push_outcome(KIND_RESPOND, ev.worker, t, own_client[t]);
                end
            end
            CMD_ONLINE: begin
                boot_pending = 1'b0;
                s = -1;
                for (int i = 0; i < n; i++)
                    if (s < 0 && !live[i]) s = i;
                if (s >= 0) begin
                    live[s] = 1; load[s] = 0; has_proj[s] = 0; proj_tag[s] = 0;
                    live_cnt++;
                    push_outcome(KIND_FILLED, s, 8'd0, 16'd0);
                end else push_outcome(KIND_NO_SLOT, 0, 8'd0, 16'd0);
            end
            default: begin
                while (nq_cnt > 0) begin
                    s = normal_target();
                    if (s < 0) break;
                    give_job(s, nq[nq_head][7:0], nq[nq_head][23:8], 1'b0);
                    nq_head = (nq_head + 1) % NQ_DEPTH;
                    nq_cnt--;
                end
                drain_projects();
                for (int i = 1; i < n && live_cnt > 1; i++) begin
                    if (live[i] && load[i] == 0) begin
                        live[i] = 0; has_proj[i] = 0; proj_tag[i] = 0;
                        live_cnt--;
                        push_outcome(KIND_KILL, i, 8'd0, 16'd0);
                    end
                end
            end
        endcase
        if (expected_q.size() > before_n) expected_q[$].last = 1'b1;
        return expected_q.size() - before_n;
    endfunction

    // Result checking and receiver stall pattern.
    logic [3:0] stall_lfsr = 4'b1001;
    int stall_phase = 0;
    always @(posedge aclk) begin
        outcome_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.kind = kind_t'(m_tuser[2:0]);
            got.slot = m_tdata[1:0];
            got.job_tag = m_tdata[9:2];
            got.client_id = m_tdata[25:10];
            got.last = m_tlast;
            if (expected_q.size() == 0) begin
                $error("unexpected result kind=%0d slot=%0d tag=%0d", got.kind, got.slot,
                       got.job_tag);
                errors++;
            end else begin
                want = expected_q.pop_front();
                if (got.kind != want.kind) begin
                    $error("kind: expected %0d actual %0d", want.kind, got.kind); errors++;
                end
                if (got.slot != want.slot) begin
                    $error("slot: expected %0d actual %0d", want.slot, got.slot); errors++;
                end
                if (got.job_tag != want.job_tag) begin
                    $error("job_tag: expected %0d actual %0d", want.job_tag, got.job_tag);
                    errors++;
                end
                if (got.client_id != want.client_id) begin
                    $error("client_id: expected %0d actual %0d", want.client_id,
                           got.client_id);
                    errors++;
                end
                if (got.last != want.last) begin
                    $error("last: expected %0d actual %0d", want.last, got.last); errors++;
                end
            end
        end
        // Stalls come in phases: none, an LFSR pattern, then heavy random stalling.
        stall_phase <= (stall_phase + 1) % 600;
        stall_lfsr <= {stall_lfsr[2:0], stall_lfsr[3] ^ stall_lfsr[2]};
        if (stall_phase < 200) m_tready <= 1'b1;
        else if (stall_phase < 400) m_tready <= stall_lfsr[0];
        else m_tready <= ($urandom_range(3, 0) == 0);
    end

    // Watchdog on cycles without any input or output handshake.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    int burst_left = 0;

    // Within a burst s_tvalid stays high and the next transaction follows at once.
    task automatic send_event(event_t ev);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(6, 0);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(8, 1);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= {6'd0, ev.tag, ev.worker, ev.client};
        s_tuser <= {ev.req_class, ev.command};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        void'(predict_event(ev));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        // A tick with nothing to report may still be scanning slots.
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        case (idx)
            CFG_WORKER_COUNT:   cur_workers = val[2:0];
            CFG_MAIN_LIMIT:     cur_main_limit = val;
            CFG_WORKER_LIMIT:   cur_worker_limit = val;
            default:            cur_grow = val[5:0];
        endcase
    endtask

    function automatic event_t make_event(cmd_t c, logic [1:0] cls, logic [15:0] cl,
                                          logic [1:0] w, logic [7:0] t);
        event_t e;
        e.command = c; e.req_class = cls; e.client = cl; e.worker = w; e.tag = t;
        return e;
    endfunction

    function automatic event_t random_event();
        int pick;
        logic [7:0] t;
        pick = $urandom_range(99, 0);
        t = tag_next - 8'($urandom_range(12, 1));
        if (pick < 45)
            return make_event(CMD_REQUEST, 2'($urandom_range(3, 0)), 16'($urandom),
                              2'($urandom), 8'($urandom));
        if (pick < 70) begin
            // Mostly genuine responses; sometimes a wrong slot or stale tag.
            if ($urandom_range(4, 0) != 0 && own_valid[t])
                return make_event(CMD_RESPONSE, 2'($urandom), 16'($urandom), own_slot[t], t);
            return make_event(CMD_RESPONSE, 2'($urandom), 16'($urandom), 2'($urandom),
                              8'($urandom));
        end
        if (pick < 85)
            return make_event(CMD_ONLINE, 2'($urandom), 16'($urandom), 2'($urandom),
                              8'($urandom));
        return make_event(CMD_TICK, 2'($urandom), 16'($urandom), 2'($urandom), 8'($urandom));
    endfunction

    // The fixed kind of a directed row is the first outcome it left in the store, which is
    // still waiting when the transaction is accepted since results take cycles to appear.
    function automatic bit predict_check_kind(kind_t k);
        for (int i = expected_q.size() - 1; i >= 0; i--)
            if (expected_q[i].last) begin
                int first;
                first = i;
                while (first > 0 && !expected_q[first - 1].last) first--;
                return expected_q[first].kind != k;
            end
        return 1'b1;
    endfunction

    row_t directed [24];
    logic [7:0] limit_pick;

    initial begin
        row_t r;
        reset_predictor();
        directed[0]  = '{make_event(CMD_TICK, 2'd0, 16'd0, 2'd0, 8'd0), 1'b0, KIND_DISPATCH};
        directed[1]  = '{make_event(CMD_RESPONSE, 2'd0, 16'd0, 2'd0, 8'd0), 1'b0,
                         KIND_DISPATCH};
        directed[2]  = '{make_event(CMD_REQUEST, 2'd1, 16'hFFFF, 2'd3, 8'hFF), 1'b1,
                         KIND_QUEUED};
        directed[3]  = '{make_event(CMD_REQUEST, 2'd2, 16'h0000, 2'd0, 8'd0), 1'b1,
                         KIND_START};
        directed[4]  = '{make_event(CMD_ONLINE, 2'd0, 16'd0, 2'd0, 8'd0), 1'b1, KIND_FILLED};
        directed[5]  = '{make_event(CMD_TICK, 2'd3, 16'hFFFF, 2'd3, 8'hFF), 1'b0,
                         KIND_DISPATCH};
        directed[6]  = '{make_event(CMD_REQUEST, 2'd1, 16'h8001, 2'd0, 8'd0), 1'b1,
                         KIND_DISPATCH};
        directed[7]  = '{make_event(CMD_REQUEST, 2'd3, 16'h7FFE, 2'd0, 8'd0), 1'b0,
                         KIND_DISPATCH};
        directed[8]  = '{make_event(CMD_ONLINE, 2'd0, 16'd0, 2'd0, 8'd0), 1'b1, KIND_FILLED};
        directed[9]  = '{make_event(CMD_ONLINE, 2'd0, 16'd0, 2'd0, 8'd0), 1'b1, KIND_FILLED};
        directed[10] = '{make_event(CMD_ONLINE, 2'd0, 16'd0, 2'd0, 8'd0), 1'b1, KIND_FILLED};
        directed[11] = '{make_event(CMD_ONLINE, 2'd0, 16'd0, 2'd0, 8'd0), 1'b1, KIND_NO_SLOT};
        directed[12] = '{make_event(CMD_REQUEST, 2'd2, 16'h1234, 2'd0, 8'd0), 1'b0,
                         KIND_DISPATCH};
        directed[13] = '{make_event(CMD_REQUEST, 2'd2, 16'h4321, 2'd0, 8'd0), 1'b0,
                         KIND_DISPATCH};
        directed[14] = '{make_event(CMD_RESPONSE, 2'd0, 16'd0, 2'd0, 8'd1), 1'b1,
                         KIND_RESPOND};
        directed[15] = '{make_event(CMD_RESPONSE, 2'd0, 16'd0, 2'd0, 8'd1), 1'b0,
                         KIND_DISPATCH};
        directed[16] = '{make_event(CMD_RESPONSE, 2'd0, 16'd0, 2'd3, 8'd2), 1'b0,
                         KIND_DISPATCH};
        directed[17] = '{make_event(CMD_RESPONSE, 2'd0, 16'd0, 2'd2, 8'd200), 1'b0,
                         KIND_DISPATCH};
        directed[18] = '{make_event(CMD_REQUEST, 2'd0, 16'hAAAA, 2'd0, 8'd0), 1'b0,
                         KIND_DISPATCH};
        directed[19] = '{make_event(CMD_REQUEST, 2'd0, 16'h5555, 2'd0, 8'd0), 1'b0,
                         KIND_DISPATCH};
        directed[20] = '{make_event(CMD_TICK, 2'd0, 16'd0, 2'd0, 8'd0), 1'b0, KIND_DISPATCH};
        directed[21] = '{make_event(CMD_TICK, 2'd0, 16'd0, 2'd0, 8'd0), 1'b0, KIND_DISPATCH};
        directed[22] = '{make_event(CMD_RESPONSE, 2'd0, 16'd0, 2'd1, 8'd255), 1'b0,
                         KIND_DISPATCH};
        directed[23] = '{make_event(CMD_TICK, 2'd0, 16'd0, 2'd0, 8'd0), 1'b0, KIND_DISPATCH};

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i]) begin
            r = directed[i];
            send_event(r.ev);
            if (r.has_fixed && predict_check_kind(r.fixed_kind)) begin
                $error("directed row %0d: kind expected %0d", i, r.fixed_kind);
                errors++;
            end
        end
        wait_drained();

        // Random phases under different register settings, extremes included.
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: limit_pick = 8'd0;
                1: limit_pick = 8'd255;
                2: limit_pick = 8'd1;
                default: limit_pick = 8'($urandom_range(6, 1));
            endcase
            write_reg(CFG_WORKER_COUNT, (phase == 0) ? 8'd1 : (phase == 1) ? 8'd4 :
                      (phase == 2) ? 8'd7 : 8'($urandom_range(4, 1)));
            write_reg(CFG_MAIN_LIMIT, limit_pick);
            write_reg(CFG_WORKER_LIMIT, (phase == 1) ? 8'd0 : 8'($urandom_range(8, 1)));
            write_reg(CFG_GROW_THRESHOLD, (phase == 0) ? 8'd0 : (phase == 1) ? 8'd32 :
                      8'($urandom_range(32, 0)));
            cfg_wr_en <= 1'b0;
            for (int k = 0; k < 16; k++) send_event(random_event());
            wait_drained();
        end

        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
